[hdl/biq_pkg.sv]
package biq_pkg;

    localparam int NUM_COEF   = 5;
    localparam int COEF_W     = 32;
    localparam int COEF_IDX_W = 3;
    localparam int COEF_FRAC  = 28;
    localparam int SAMPLE_W   = 24;
    localparam int DLY_W      = 32;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = 64;
    localparam int Q_W        = ACC_W - COEF_FRAC;
    localparam int NUM_STEPS  = 8;
    localparam int STEP_W     = $clog2(NUM_STEPS);

    // Coefficient register indexes.
    localparam logic [COEF_IDX_W-1:0] IDX_B0 = 3'd0;
    localparam logic [COEF_IDX_W-1:0] IDX_B1 = 3'd1;
    localparam logic [COEF_IDX_W-1:0] IDX_B2 = 3'd2;
    localparam logic [COEF_IDX_W-1:0] IDX_A1 = 3'd3;
    localparam logic [COEF_IDX_W-1:0] IDX_A2 = 3'd4;

    // Accumulator operations.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    // Base term loaded into the accumulator.
    localparam logic [1:0] BASE_D1   = 2'd0;
    localparam logic [1:0] BASE_D2   = 2'd1;
    localparam logic [1:0] BASE_ZERO = 2'd2;

    // Write-back targets.
    localparam logic [1:0] WB_NONE = 2'd0;
    localparam logic [1:0] WB_Y    = 2'd1;
    localparam logic [1:0] WB_N1   = 2'd2;
    localparam logic [1:0] WB_N2   = 2'd3;

    localparam logic signed [Q_W-1:0] OUT_MAX = 36'sh0007FFFFF;
    localparam logic signed [Q_W-1:0] OUT_MIN = 36'shFFF800000;
    localparam logic signed [Q_W-1:0] DLY_MAX = 36'sh07FFFFFFF;
    localparam logic signed [Q_W-1:0] DLY_MIN = 36'shF80000000;
    localparam logic signed [ACC_W-1:0] HALF_LSB = 64'sd134217728;

    localparam logic [COEF_W-1:0] B0_RESET = 32'h1000_0000;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

    typedef struct packed {
        logic [COEF_IDX_W-1:0] coef_sel;
        logic                  dat_y;
        logic [1:0]            acc_op;
        logic [1:0]            base_sel;
        logic [1:0]            wb;
        logic                  last;
    } ctl_word_t;

    typedef struct packed {
        logic [DLY_W-1:0] value;
        logic             clip;
    } rnd_sat_t;

    // Microcode: one control word per step of a sample.
    function automatic ctl_word_t micro_rom(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        w = '{coef_sel: IDX_B0, dat_y: 1'b0, acc_op: ACC_HOLD, base_sel: BASE_ZERO,
              wb: WB_NONE, last: 1'b0};
        case (step)
            3'd0: w.coef_sel = IDX_B0;
            3'd1:
            begin
                w.coef_sel = IDX_B1;
                w.acc_op   = ACC_LOAD;
                w.base_sel = BASE_D1;
            end
            3'd2:
            begin
                w.acc_op   = ACC_LOAD;
                w.base_sel = BASE_D2;
                w.wb       = WB_Y;
            end
            3'd3:
            begin
                w.coef_sel = IDX_A1;
                w.dat_y    = 1'b1;
            end
            3'd4:
            begin
                w.coef_sel = IDX_B2;
                w.acc_op   = ACC_SUB;
            end
            3'd5:
            begin
                w.coef_sel = IDX_A2;
                w.dat_y    = 1'b1;
                w.acc_op   = ACC_LOAD;
                w.base_sel = BASE_ZERO;
                w.wb       = WB_N1;
            end
            3'd6: w.acc_op = ACC_SUB;
            3'd7:
            begin
                w.wb   = WB_N2;
                w.last = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

    // Round to Q.23 (half up) and saturate to the output or delay range.
    function automatic rnd_sat_t rnd_sat(input logic signed [ACC_W-1:0] acc,
                                         input logic narrow);
        logic signed [ACC_W-1:0] sum;
        logic signed [Q_W-1:0]   q;
        logic signed [Q_W-1:0]   hi;
        logic signed [Q_W-1:0]   lo;
        rnd_sat_t                r;
        sum = acc + HALF_LSB;
        q   = sum[ACC_W-1:COEF_FRAC];
        hi  = narrow ? OUT_MAX : DLY_MAX;
        lo  = narrow ? OUT_MIN : DLY_MIN;
        r.clip = 1'b0;
        if (q > hi)
        begin
            r.value = hi[DLY_W-1:0];
            r.clip  = 1'b1;
        end
        else if (q < lo)
        begin
            r.value = lo[DLY_W-1:0];
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = q[DLY_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/biquad_iir_filter.sv]
// Biquad IIR section, transposed direct form II, fixed point.
// Input samples (signed Q1.23) arrive on the s_axis stream; each transfer
// yields exactly one filtered sample on the m_axis stream, with the clip
// flag in tuser set when the output or a delay register saturated.
// The five Q4.28 coefficients are written through the cfg channel
// (index 0..4 = b0, b1, b2, a1, a2); any valid write clears both delay
// registers, and writes to other indexes are ignored. Write them only while
// no sample is in flight.
// A sample runs through an eight-step microcode program that shares one
// 32 x 24 multiplier and one accumulator over the five products. The result
// becomes valid in the same cycle as the input is ready again for the next
// sample; a new sample is not taken while one is still in flight.
// Reset restores b0 = 1.0, the other coefficients and both delays to zero.
// If the receiver stalls, the finished result waits in the output register;
// the next sample is accepted and computed, and its last step waits until
// the pending result has been transferred.
module biquad_iir_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [biq_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [23:0] sample_in
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [biq_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [23:0] sample_out
    output logic                         m_axis_tuser,   // [0] clipped
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [biq_pkg::COEF_IDX_W-1:0] cfg_index,
    input  logic [biq_pkg::COEF_W-1:0]   cfg_data
);
    import biq_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic              out_clip_reg;
    coef_bank_t        coef_reg;
    ctl_word_t         ctl;
    logic              in_xfer;
    logic              cfg_xfer;
    logic              cfg_hit;
    logic              step_en;
    logic              finish;
    logic [SAMPLE_W-1:0] res_y;
    logic              res_clip;

    assign ctl      = micro_rom(step_reg);
    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign cfg_xfer = cfg_valid & cfg_ready;
    assign cfg_hit  = cfg_xfer & (cfg_index < COEF_IDX_W'(NUM_COEF));
    // The last step writes the output register, so it holds while that is full and not taken.
    assign step_en  = busy_reg & (~ctl.last | ~out_valid_reg | m_axis_tready);
    assign finish   = step_en & ctl.last;

    assign s_axis_tready = ~busy_reg;
    assign cfg_ready     = ~busy_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_clip_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (in_xfer)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (step_en)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            coef_reg      <= {{((NUM_COEF-1)*COEF_W){1'b0}}, B0_RESET};
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_hit)
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= res_y;
            out_clip_reg <= res_clip;
        end
    end

    biq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .step_en  (step_en),
        .load_x   (in_xfer),
        .x_in     (s_axis_tdata),
        .clr_dly  (cfg_hit),
        .coefs    (coef_reg),
        .res_y    (res_y),
        .res_clip (res_clip)
    );

endmodule

[hdl/biq_datapath.sv]
module biq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  biq_pkg::ctl_word_t                ctl,
    input  logic                              step_en,
    input  logic                              load_x,
    input  logic [biq_pkg::SAMPLE_W-1:0]      x_in,
    input  logic                              clr_dly,
    input  biq_pkg::coef_bank_t               coefs,
    output logic [biq_pkg::SAMPLE_W-1:0]      res_y,
    output logic                              res_clip
);
    import biq_pkg::*;

    logic [SAMPLE_W-1:0]     x_reg;
    logic [SAMPLE_W-1:0]     y_reg;
    logic [SAMPLE_W-1:0]     y_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] prod_ext;
    logic [DLY_W-1:0]        n1_reg;
    logic [DLY_W-1:0]        d1_reg;
    logic [DLY_W-1:0]        d2_reg;
    logic                    clip_reg;
    logic [COEF_W-1:0]       coef_mux;
    logic [SAMPLE_W-1:0]     data_mux;
    rnd_sat_t                rs;

    always_comb
    begin
        case (ctl.coef_sel)
            IDX_B0:  coef_mux = coefs[0];
            IDX_B1:  coef_mux = coefs[1];
            IDX_B2:  coef_mux = coefs[2];
            IDX_A1:  coef_mux = coefs[3];
            IDX_A2:  coef_mux = coefs[4];
            default: coef_mux = '0;
        endcase
    end

    assign data_mux  = ctl.dat_y ? y_reg : x_reg;
    assign prod_next = $signed(coef_mux) * $signed(data_mux);
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        case (ctl.base_sel)
            BASE_D1: base = $signed({{(ACC_W-DLY_W-COEF_FRAC){d1_reg[DLY_W-1]}},
                                     d1_reg, {COEF_FRAC{1'b0}}});
            BASE_D2: base = $signed({{(ACC_W-DLY_W-COEF_FRAC){d2_reg[DLY_W-1]}},
                                     d2_reg, {COEF_FRAC{1'b0}}});
            default: base = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.acc_op)
            ACC_LOAD: acc_next = base + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    assign rs       = rnd_sat(acc_reg, ctl.wb == WB_Y);
    assign y_next   = rs.value[SAMPLE_W-1:0];
    assign res_y    = y_reg;
    assign res_clip = clip_reg | ((ctl.wb == WB_N2) & rs.clip);

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load_x)
        begin
            x_reg <= x_in;
        end
        if (step_en)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            if (ctl.wb == WB_Y)
            begin
                y_reg <= y_next;
            end
            if (ctl.wb == WB_N1)
            begin
                n1_reg <= rs.value;
            end
        end
    end

    // Filter state and the per-sample saturation flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg   <= '0;
            d2_reg   <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            if (load_x)
            begin
                clip_reg <= 1'b0;
            end
            else if (step_en && ctl.wb != WB_NONE && rs.clip)
            begin
                clip_reg <= 1'b1;
            end
            if (clr_dly)
            begin
                d1_reg <= '0;
                d2_reg <= '0;
            end
            else if (step_en && ctl.wb == WB_N2)
            begin
                d1_reg <= n1_reg;
                d2_reg <= rs.value;
            end
        end
    end

endmodule

[hdl/biq_checker.sv]
module biq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [biq_pkg::SAMPLE_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser,
    input logic                         cfg_ready
);
    import biq_pkg::*;

    // A held result keeps its value until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // One sample at a time: no new input or coefficient write in the cycle after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready)
        else $error("input taken while a sample is in flight");

    // A result is waiting once the microcode steps of an input transfer have run and written the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##9 m_axis_tvalid)
        else $error("result missing after input transfer");

    // A new result only appears as the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared while the sequencer was busy");

endmodule

bind biquad_iir_filter biq_checker u_biq_checker (.*);
